// File: design/upc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upc_pkg
// Types, character constants and helpers for the URL percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
    localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } upc_phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } upc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } upc_out_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'h0, nib};
        return (nib > 4'd9) ? n8 + HEX_ALPHA_OFS : n8 + HEX_DIGIT_OFS;
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // lenient digit: letters give 10..35, digits 0..9, anything else 0
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (is_upper(c)) begin
            v = c - 8'h37;
        end else if (is_lower(c)) begin
            v = c - 8'h57;
        end else if (is_digit(c)) begin
            v = c - 8'h30;
        end else begin
            v = 8'h00;
        end
        return v[5:0];
    endfunction

    function automatic logic passes_plain(input logic [7:0] c);
        return is_upper(c) || is_lower(c) || is_digit(c) || (c == CH_DASH) ||
               (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
    endfunction

endpackage
`default_nettype wire

// File: design/url_percent_codec.sv
`default_nettype none
// An item's first result passes the input item register and then the output
// register to reach m_valid. Throughput: one item per cycle when it gives no
// result, or one while m_ready holds no output back; an escaped byte in encode
// mode gives three results, one at a time through the single output register.
// Reset (aresetn low, synchronous): encode mode, no escape open, both item
// registers empty.
// ----------------------------------------------------------------------------
// url_percent_codec
// Byte-stream URL form encoder/decoder with a one-bit mode register.
// ----------------------------------------------------------------------------
module url_percent_codec
    import upc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    cfg_we,
    input  wire logic    cfg_wdata,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire upc_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output upc_out_t     m_data
);

    logic       mode_reg;
    upc_phase_t phase_reg, phase_next;
    logic [3:0] nib_reg, nib_next;
    logic       in_vld_reg;
    upc_in_t    in_reg;
    logic       out_vld_reg;
    upc_out_t   out_reg;
    logic [1:0] idx_reg;

    logic [1:0] run_cnt;
    upc_out_t   res;
    logic [5:0] dv;
    logic [7:0] c;
    logic       lst;
    logic       slot_free, step, emit, run_done;

    assign c   = in_reg.in_byte;
    assign lst = in_reg.in_last;
    assign dv  = digit_value(c);

    // result for position idx_reg of the current run, plus escape update
    always_comb begin
        run_cnt    = 2'd1;
        res        = '{out_byte: c, run_last: 1'b1, string_end: lst};
        phase_next = phase_reg;
        nib_next   = nib_reg;
        if (mode_reg == MODE_ENCODE) begin
            if (passes_plain(c)) begin
                res.out_byte = c;
            end else if (c == CH_SPACE) begin
                res.out_byte = CH_PLUS;
            end else begin
                run_cnt = 2'd3;
                case (idx_reg)
                    2'd0: begin
                        res = '{out_byte: CH_PCT, run_last: 1'b0, string_end: 1'b0};
                    end
                    2'd1: begin
                        res = '{out_byte: hex_char(c[7:4]), run_last: 1'b0,
                                string_end: 1'b0};
                    end
                    default: begin
                        res.out_byte = hex_char(c[3:0]);
                    end
                endcase
            end
        end else begin
            case (phase_reg)
                ESC_HIGH: begin
                    if (lst) begin
                        res        = '{out_byte: {dv[3:0], 4'h0}, run_last: 1'b1,
                                       string_end: 1'b1};
                        phase_next = ESC_IDLE;
                        nib_next   = 4'h0;
                    end else begin
                        run_cnt    = 2'd0;
                        phase_next = ESC_LOW;
                        nib_next   = dv[3:0];
                    end
                end
                ESC_LOW: begin
                    res.out_byte = {nib_reg, 4'h0} + {2'b00, dv};
                    phase_next   = ESC_IDLE;
                    nib_next     = 4'h0;
                end
                default: begin
                    phase_next = ESC_IDLE;
                    if (c == CH_PCT) begin
                        nib_next = 4'h0;
                        if (lst) begin
                            res.out_byte = 8'h00;
                        end else begin
                            run_cnt    = 2'd0;
                            phase_next = ESC_HIGH;
                        end
                    end else if (c == CH_PLUS) begin
                        res.out_byte = CH_SPACE;
                    end
                end
            endcase
        end
    end

    assign slot_free = !out_vld_reg || m_ready;
    assign step      = in_vld_reg && ((run_cnt == 2'd0) || slot_free);
    assign emit      = step && (run_cnt != 2'd0);
    assign run_done  = step && ((run_cnt == 2'd0) || (idx_reg == run_cnt - 2'd1));
    assign s_ready   = !in_vld_reg || run_done;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_ENCODE;
            phase_reg   <= ESC_IDLE;
            nib_reg     <= 4'h0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            if (cfg_we) begin
                mode_reg  <= cfg_wdata;
                phase_reg <= ESC_IDLE;
                nib_reg   <= 4'h0;
            end else if (run_done) begin
                phase_reg <= phase_next;
                nib_reg   <= nib_next;
            end
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (emit) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (run_done) begin
                idx_reg <= 2'd0;
            end else if (emit) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (emit) begin
            out_reg <= res;
        end
    end

    // mid-run position only while an item is held
    a_idx_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 2'd0) |-> in_vld_reg)
        else $error("run position set with no item held");

    // decode runs are at most a single result
    a_dec_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_DECODE) |-> (idx_reg == 2'd0))
        else $error("multi-result run in decode mode");

    a_esc_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != ESC_IDLE) |-> (mode_reg == MODE_DECODE))
        else $error("escape open in encode mode");

    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> ((phase_reg == ESC_IDLE) && (nib_reg == 4'h0)))
        else $error("mode write left escape state");

    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.string_end) |-> m_data.run_last)
        else $error("string end without run end");

endmodule
`default_nettype wire
